>>> design/first_fit_heap_allocator_top_assert.svh
// Assertion macros for the first-fit heap allocator.
// FFHA_ASSERT is gated by the active-low reset; FFHA_ASSERT_ALWAYS is checked in reset too.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FFHA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ffha assertion failed");
`define FFHA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ffha assertion failed");
`else
`define FFHA_ASSERT(lbl, clk, rstn, prop)
`define FFHA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> design/ffha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;

  localparam int MaxSegments  = 64;
  localparam int HeaderBytes  = 12;
  localparam int HeapAddrBits = 20;

  localparam int SegIdxW = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int CntW    = $clog2(MaxSegments + 1);
  localparam int SizeW   = HeapAddrBits;
  localparam int SpanW   = HeapAddrBits + 1;

  localparam int BaseW   = 32;
  localparam int BytesW  = 21;
  localparam int ReqW    = 32;
  localparam int StatusW = 2;
  localparam int CfgDataW = 32;
  localparam int CfgIdxW  = 1;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  localparam logic [StatusW-1:0] StatusDone    = 2'd0;
  localparam logic [StatusW-1:0] StatusFail    = 2'd1;
  localparam logic [StatusW-1:0] StatusIgnored = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgHeapBase  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgHeapBytes = 1'd1;

  localparam logic [BytesW-1:0] HeapBytesReset = BytesW'(1 << 20);

  typedef struct packed {
    logic             used;
    logic [SizeW-1:0] size;
  } entry_t;

  // heap span clamped to the addressable region
  function automatic logic [SpanW-1:0] span_of(input logic [BytesW-1:0] bytes);
    logic [32:0] bx;
    logic [32:0] lim;
    bx  = 33'(bytes);
    lim = 33'(1) << HeapAddrBits;
    return SpanW'((bx > lim) ? lim : bx);
  endfunction

endpackage
`default_nettype wire

>>> design/ffha_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ffha_req_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [ffha_pkg::ReqW-1:0] request_bytes;
  logic [ffha_pkg::BaseW-1:0] free_addr;

  modport source (output valid, output cmd, output request_bytes, output free_addr,
                  input ready);
  modport sink   (input valid, input cmd, input request_bytes, input free_addr,
                  output ready);
endinterface

interface ffha_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ffha_pkg::BaseW-1:0]    result_addr;
  logic [ffha_pkg::StatusW-1:0]  status;
  logic [ffha_pkg::BytesW-1:0]   free_bytes;

  modport source (output valid, output result_addr, output status, output free_bytes,
                  input ready);
  modport sink   (input valid, input result_addr, input status, input free_bytes,
                  output ready);
endinterface
`default_nettype wire

>>> design/ffha_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ffha_ram #(
  parameter int Depth = 64,
  parameter int Width = 21
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule
`default_nettype wire

>>> design/first_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// First-fit heap allocator: the segment table lives in one single-port RAM with a
// registered read, and each request walks it one entry at a time (read, then
// check). An allocate that lands on a free segment marks it used; on a split it
// first moves later entries up and writes the remainder as a new segment. A free
// also reads the next entry unless it hit the last segment, and moves later
// entries down on a merge; a request that misses every segment walks the whole
// table. A finished result waits while the previous one is held by the receiver.
// All table accesses share the single RAM port. After reset the ST_INIT state
// writes the first segment before the first request is taken; config writes rebuild
// the table at once and must be issued only while the block is idle.
module first_fit_heap_allocator_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ffha_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ffha_pkg::CfgDataW-1:0]  cfg_wdata_i,
  ffha_req_if.sink                            req_i,
  ffha_rsp_if.source                          rsp_o
);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_RD, ST_CHK, ST_NEXT_RD, ST_NEXT_CHK, ST_MERGE,
    ST_SHDN_RD, ST_SHDN_WR, ST_SHUP_RD, ST_SHUP_WR, ST_SPLIT_WR, ST_LO_WR, ST_FINISH
  } state_e;

  localparam int CntW  = ffha_pkg::CntW;
  localparam int SizeW = ffha_pkg::SizeW;
  localparam int SpanW = ffha_pkg::SpanW;
  localparam int SegW  = ffha_pkg::SegIdxW;

  state_e                        state_q;
  logic [ffha_pkg::BaseW-1:0]    base_q;
  logic [ffha_pkg::BytesW-1:0]   bytes_q;
  logic [CntW-1:0]               count_q;
  logic [SpanW-1:0]              free_q;
  logic                          cmd_q;
  logic [32:0]                   want_q;
  logic [ffha_pkg::BaseW-1:0]    addr_q;
  logic [CntW-1:0]               idx_q;
  logic [CntW-1:0]               k_q;
  logic [1:0]                    r_q;
  logic [SpanW-1:0]              offset_q;
  ffha_pkg::entry_t              prev_q;
  logic                          prev_valid_q;
  ffha_pkg::entry_t              next_q;
  logic                          next_valid_q;
  logic [SizeW-1:0]              hit_q;
  logic [SizeW-1:0]              rem_q;
  logic [SizeW-1:0]              lo_q;
  logic [ffha_pkg::BaseW-1:0]    res_addr_q;
  logic [ffha_pkg::StatusW-1:0]  res_status_q;
  logic                          rsp_valid_q;
  logic [ffha_pkg::BaseW-1:0]    rsp_addr_q;
  logic [ffha_pkg::StatusW-1:0]  rsp_status_q;
  logic [ffha_pkg::BytesW-1:0]   rsp_free_q;

  logic                          ram_we;
  logic                          ram_re;
  logic [SegW-1:0]               ram_addr;
  ffha_pkg::entry_t              ram_wdata;
  ffha_pkg::entry_t              ram_rdata;

  ffha_ram #(
    .Depth (ffha_pkg::MaxSegments),
    .Width ($bits(ffha_pkg::entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // config rebuild values
  logic [ffha_pkg::BaseW-1:0]  cfg_base;
  logic [ffha_pkg::BytesW-1:0] cfg_bytes;
  logic [SpanW-1:0]            cfg_span;
  logic                        cfg_fits;
  logic [SizeW-1:0]            cfg_size0;
  logic [SpanW-1:0]            rst_span;
  logic [SizeW-1:0]            init_size0;

  always_comb begin
    cfg_base  = base_q;
    cfg_bytes = bytes_q;
    if (cfg_idx_i == ffha_pkg::CfgHeapBase) begin
      cfg_base = cfg_wdata_i[ffha_pkg::BaseW-1:0];
    end else begin
      cfg_bytes = cfg_wdata_i[ffha_pkg::BytesW-1:0];
    end
    cfg_span  = ffha_pkg::span_of(cfg_bytes);
    cfg_fits  = cfg_span >= SpanW'(ffha_pkg::HeaderBytes);
    cfg_size0 = SizeW'(cfg_span - SpanW'(ffha_pkg::HeaderBytes));
    rst_span   = ffha_pkg::span_of(bytes_q);
    init_size0 = SizeW'(rst_span - SpanW'(ffha_pkg::HeaderBytes));
  end

  // scan evaluation
  logic [ffha_pkg::BaseW-1:0] payload;
  logic [33:0]                size_x;
  logic                       alloc_hit;
  logic                       split;
  logic                       free_hit;
  logic                       last_entry;
  logic [SpanW-1:0]           offset_next;

  always_comb begin
    payload = base_q + ffha_pkg::BaseW'(offset_q) + ffha_pkg::BaseW'(ffha_pkg::HeaderBytes);
    size_x  = 34'(ram_rdata.size);
    alloc_hit = !ram_rdata.used && (size_x >= 34'(want_q));
    split = (size_x > 34'(want_q) + 34'(ffha_pkg::HeaderBytes + 4))
            && (count_q < CntW'(ffha_pkg::MaxSegments));
    free_hit = ram_rdata.used && (payload == addr_q);
    last_entry = (idx_q + CntW'(1)) >= count_q;
    offset_next = offset_q + SpanW'(ram_rdata.size) + SpanW'(ffha_pkg::HeaderBytes);
  end

  // merge of a freed segment with free neighbors
  logic             pf;
  logic             nf;
  logic [CntW-1:0]  merge_j;
  logic [SizeW-1:0] merge_size;
  logic [1:0]       merge_r;
  logic [CntW:0]    shdn_src;

  always_comb begin
    pf = prev_valid_q && !prev_q.used;
    nf = next_valid_q && !next_q.used;
    merge_j = pf ? idx_q - CntW'(1) : idx_q;
    merge_r = {1'b0, pf} + {1'b0, nf};
    merge_size = hit_q
               + (pf ? prev_q.size + SizeW'(ffha_pkg::HeaderBytes) : '0)
               + (nf ? next_q.size + SizeW'(ffha_pkg::HeaderBytes) : '0);
    shdn_src = (CntW+1)'(k_q) + (CntW+1)'(r_q);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    if (cfg_we_i) begin
      ram_we    = 1'b1;
      ram_wdata = '{used: 1'b0, size: cfg_size0};
    end else begin
      unique case (state_q)
        ST_INIT: begin
          ram_we    = 1'b1;
          ram_wdata = '{used: 1'b0, size: init_size0};
        end
        ST_RD: begin
          ram_re   = 1'b1;
          ram_addr = SegW'(idx_q);
        end
        ST_NEXT_RD: begin
          ram_re   = 1'b1;
          ram_addr = SegW'(idx_q + CntW'(1));
        end
        ST_MERGE: begin
          ram_we    = 1'b1;
          ram_addr  = SegW'(merge_j);
          ram_wdata = '{used: 1'b0, size: merge_size};
        end
        ST_SHDN_RD: begin
          ram_re   = 1'b1;
          ram_addr = SegW'(shdn_src);
        end
        ST_SHDN_WR, ST_SHUP_WR: begin
          ram_we    = 1'b1;
          ram_addr  = SegW'(k_q);
          ram_wdata = ram_rdata;
        end
        ST_SHUP_RD: begin
          ram_re   = 1'b1;
          ram_addr = SegW'(k_q - CntW'(1));
        end
        ST_SPLIT_WR: begin
          ram_we    = 1'b1;
          ram_addr  = SegW'(idx_q + CntW'(1));
          ram_wdata = '{used: 1'b0, size: rem_q};
        end
        ST_LO_WR: begin
          ram_we    = 1'b1;
          ram_addr  = SegW'(idx_q);
          ram_wdata = '{used: 1'b1, size: lo_q};
        end
        default: begin
        end
      endcase
    end
  end

  // a new result replaces the one that leaves in the same cycle
  logic rsp_load;
  assign rsp_load = !cfg_we_i && (state_q == ST_FINISH) && (!rsp_valid_q || rsp_o.ready);

  assign req_i.ready       = (state_q == ST_IDLE) && !cfg_we_i;
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.result_addr = rsp_addr_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.free_bytes  = rsp_free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      base_q       <= '0;
      bytes_q      <= ffha_pkg::HeapBytesReset;
      count_q      <= '0;
      free_q       <= '0;
      rsp_valid_q  <= 1'b0;
      idx_q        <= '0;
      k_q          <= '0;
      r_q          <= '0;
      prev_valid_q <= 1'b0;
      next_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_o.ready && !rsp_load) begin
        rsp_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        base_q  <= cfg_base;
        bytes_q <= cfg_bytes;
        count_q <= cfg_fits ? CntW'(1) : '0;
        free_q  <= cfg_fits ? SpanW'(cfg_size0) : '0;
        if (state_q == ST_INIT) begin
          state_q <= ST_IDLE;
        end
      end else begin
        unique case (state_q)
          ST_INIT: begin
            if (rst_span >= SpanW'(ffha_pkg::HeaderBytes)) begin
              count_q <= CntW'(1);
              free_q  <= SpanW'(init_size0);
            end
            state_q <= ST_IDLE;
          end
          ST_IDLE: begin
            if (req_i.valid) begin
              cmd_q        <= req_i.cmd;
              want_q       <= (33'(req_i.request_bytes) + 33'd3) & ~33'd3;
              addr_q       <= req_i.free_addr;
              idx_q        <= '0;
              offset_q     <= '0;
              prev_valid_q <= 1'b0;
              next_valid_q <= 1'b0;
              res_addr_q   <= '0;
              if (count_q == '0) begin
                res_status_q <= (req_i.cmd == ffha_pkg::CmdFree) ?
                                ffha_pkg::StatusIgnored : ffha_pkg::StatusFail;
                state_q <= ST_FINISH;
              end else if (req_i.cmd == ffha_pkg::CmdAlloc && req_i.request_bytes == '0) begin
                res_status_q <= ffha_pkg::StatusFail;
                state_q <= ST_FINISH;
              end else begin
                state_q <= ST_RD;
              end
            end
          end
          ST_RD: begin
            state_q <= ST_CHK;
          end
          ST_CHK: begin
            if (cmd_q == ffha_pkg::CmdAlloc && alloc_hit) begin
              res_addr_q   <= payload;
              res_status_q <= ffha_pkg::StatusDone;
              if (split) begin
                lo_q    <= SizeW'(want_q);
                rem_q   <= SizeW'(34'(ram_rdata.size) - 34'(want_q)
                                  - 34'(ffha_pkg::HeaderBytes));
                free_q  <= free_q - SpanW'(want_q) - SpanW'(ffha_pkg::HeaderBytes);
                count_q <= count_q + CntW'(1);
                k_q     <= count_q;
                state_q <= (count_q > idx_q + CntW'(1)) ? ST_SHUP_RD : ST_SPLIT_WR;
              end else begin
                lo_q    <= ram_rdata.size;
                free_q  <= free_q - SpanW'(ram_rdata.size);
                state_q <= ST_LO_WR;
              end
            end else if (cmd_q == ffha_pkg::CmdFree && free_hit) begin
              res_status_q <= ffha_pkg::StatusDone;
              hit_q   <= ram_rdata.size;
              free_q  <= free_q + SpanW'(ram_rdata.size);
              state_q <= last_entry ? ST_MERGE : ST_NEXT_RD;
            end else begin
              prev_q       <= ram_rdata;
              prev_valid_q <= 1'b1;
              offset_q     <= offset_next;
              idx_q        <= idx_q + CntW'(1);
              if (last_entry) begin
                res_status_q <= (cmd_q == ffha_pkg::CmdFree) ?
                                ffha_pkg::StatusIgnored : ffha_pkg::StatusFail;
                res_addr_q   <= '0;
                state_q      <= ST_FINISH;
              end else begin
                state_q <= ST_RD;
              end
            end
          end
          ST_NEXT_RD: begin
            state_q <= ST_NEXT_CHK;
          end
          ST_NEXT_CHK: begin
            next_q       <= ram_rdata;
            next_valid_q <= 1'b1;
            state_q      <= ST_MERGE;
          end
          ST_MERGE: begin
            free_q <= free_q + (pf ? SpanW'(ffha_pkg::HeaderBytes) : '0)
                             + (nf ? SpanW'(ffha_pkg::HeaderBytes) : '0);
            k_q <= merge_j + CntW'(1);
            r_q <= merge_r;
            if (merge_r == 2'd0) begin
              state_q <= ST_FINISH;
            end else if ((CntW+1)'(merge_j) + (CntW+1)'(1) + (CntW+1)'(merge_r)
                         < (CntW+1)'(count_q)) begin
              state_q <= ST_SHDN_RD;
            end else begin
              count_q <= count_q - CntW'(merge_r);
              state_q <= ST_FINISH;
            end
          end
          ST_SHDN_RD: begin
            state_q <= ST_SHDN_WR;
          end
          ST_SHDN_WR: begin
            k_q <= k_q + CntW'(1);
            if (shdn_src + (CntW+1)'(1) < (CntW+1)'(count_q)) begin
              state_q <= ST_SHDN_RD;
            end else begin
              count_q <= count_q - CntW'(r_q);
              state_q <= ST_FINISH;
            end
          end
          ST_SHUP_RD: begin
            state_q <= ST_SHUP_WR;
          end
          ST_SHUP_WR: begin
            k_q     <= k_q - CntW'(1);
            state_q <= (k_q - CntW'(1) > idx_q + CntW'(1)) ? ST_SHUP_RD : ST_SPLIT_WR;
          end
          ST_SPLIT_WR: begin
            state_q <= ST_LO_WR;
          end
          ST_LO_WR: begin
            state_q <= ST_FINISH;
          end
          ST_FINISH: begin
            if (rsp_load) begin
              rsp_valid_q  <= 1'b1;
              rsp_addr_q   <= res_addr_q;
              rsp_status_q <= res_status_q;
              rsp_free_q   <= ffha_pkg::BytesW'(free_q);
              state_q      <= ST_IDLE;
            end
          end
          default: begin
            state_q <= ST_IDLE;
          end
        endcase
      end
    end
  end

`include "first_fit_heap_allocator_top_assert.svh"

  `FFHA_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CntW'(ffha_pkg::MaxSegments))
  `FFHA_ASSERT(a_rsp_from_finish, clk_i, rst_ni, $rose(rsp_valid_q) |-> $past(state_q == ST_FINISH))
  `FFHA_ASSERT(a_free_bound, clk_i, rst_ni, (state_q == ST_IDLE) |-> (free_q <= SpanW'(bytes_q)))
  `FFHA_ASSERT_ALWAYS(a_no_req_in_reset, clk_i, !rst_ni |-> !req_i.ready)

endmodule
`default_nettype wire

>>> bench/first_fit_heap_allocator_top_test.sv
`timescale 1ns / 1ps
module first_fit_heap_allocator_top_test;

  localparam int unsigned LimitCycles = 2000000;
  localparam int unsigned SegLimit = ffha_pkg::MaxSegments;
  localparam int unsigned HdrBytes = ffha_pkg::HeaderBytes;

  typedef struct packed {
    logic [ffha_pkg::BaseW-1:0]   addr;
    logic [ffha_pkg::StatusW-1:0] status;
    logic [ffha_pkg::BytesW-1:0]  free_bytes;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ffha_pkg::CfgIdxW-1:0] cfg_idx_i = ffha_pkg::CfgHeapBase;
  logic [ffha_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  ffha_req_if req_if ();
  ffha_rsp_if rsp_if ();

  first_fit_heap_allocator_top u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i(req_if.sink),
    .rsp_o(rsp_if.source)
  );

  always #5 clk_i = ~clk_i;

  // allocator shadow state
  logic [31:0] heap_base_q;
  logic [20:0] heap_bytes_q;
  logic [31:0] seg_size [SegLimit];
  logic        seg_used [SegLimit];
  int unsigned seg_count;
  logic [31:0] live_addrs [$];

  outcome_t pending_results [$];
  int unsigned error_count = 0;
  int unsigned checked_count = 0;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_off_cycles = 0;
  bit random_stall = 1'b1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void rebuild_heap();
    logic [21:0] span;
    span = (heap_bytes_q > 21'h100000) ? 22'h100000 : {1'b0, heap_bytes_q};
    for (int i = 0; i < SegLimit; i++) begin
      seg_size[i] = '0;
      seg_used[i] = 1'b0;
    end
    live_addrs.delete();
    if (span < HdrBytes) begin
      seg_count = 0;
    end else begin
      seg_size[0] = span - HdrBytes;
      seg_count = 1;
    end
  endfunction

  function automatic logic [20:0] free_sum();
    logic [31:0] total;
    total = 0;
    for (int i = 0; i < seg_count; i++)
      if (!seg_used[i]) total += seg_size[i];
    return total[20:0];
  endfunction

  function automatic void merge_neighbours();
    int unsigned i;
    i = 0;
    while (i + 1 < seg_count) begin
      if (!seg_used[i] && !seg_used[i+1]) begin
        seg_size[i] += seg_size[i+1] + HdrBytes;
        for (int k = i + 1; k + 1 < seg_count; k++) begin
          seg_size[k] = seg_size[k+1];
          seg_used[k] = seg_used[k+1];
        end
        seg_count--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic outcome_t predict_outcome(input logic cmd, input logic [31:0] req_bytes,
                                               input logic [31:0] addr);
    outcome_t res;
    logic [33:0] want;
    logic [33:0] offset;
    logic [31:0] payload;
    bit hit;
    res = '0;
    offset = '0;
    hit = 1'b0;
    if (cmd == ffha_pkg::CmdAlloc) begin
      res.status = ffha_pkg::StatusFail;
      want = ({2'b0, req_bytes} + 34'd3) & ~34'd3;
      if (req_bytes != 0) begin
        for (int i = 0; i < seg_count && !hit; i++) begin
          if (!seg_used[i] && {2'b0, seg_size[i]} >= want) begin
            if ({2'b0, seg_size[i]} > want + HdrBytes + 4 && seg_count < SegLimit) begin
              for (int k = seg_count; k > i + 1; k--) begin
                seg_size[k] = seg_size[k-1];
                seg_used[k] = seg_used[k-1];
              end
              seg_size[i+1] = seg_size[i] - want[31:0] - HdrBytes;
              seg_used[i+1] = 1'b0;
              seg_size[i] = want[31:0];
              seg_count++;
            end
            seg_used[i] = 1'b1;
            res.addr = heap_base_q + offset[31:0] + HdrBytes;
            res.status = ffha_pkg::StatusDone;
            live_addrs.push_back(res.addr);
            hit = 1'b1;
          end else begin
            offset += seg_size[i] + HdrBytes;
          end
        end
      end
    end else begin
      res.status = ffha_pkg::StatusIgnored;
      for (int i = 0; i < seg_count && !hit; i++) begin
        payload = heap_base_q + offset[31:0] + HdrBytes;
        if (seg_used[i] && payload == addr) begin
          seg_used[i] = 1'b0;
          merge_neighbours();
          res.status = ffha_pkg::StatusDone;
          hit = 1'b1;
        end
        offset += seg_size[i] + HdrBytes;
      end
      if (hit)
        foreach (live_addrs[j])
          if (live_addrs[j] == addr) begin
            live_addrs.delete(j);
            break;
          end
    end
    res.free_bytes = free_sum();
    return res;
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      checked_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", rsp_if.result_addr, 0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.result_addr !== want.addr)
          report_mismatch("result_addr", rsp_if.result_addr, want.addr);
        if (rsp_if.status !== want.status)
          report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
        if (rsp_if.free_bytes !== want.free_bytes)
          report_mismatch("free_bytes", 32'(rsp_if.free_bytes), 32'(want.free_bytes));
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  initial begin
    int unsigned gap;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        hold_off_cycles--;
      end else if (rsp_if.ready && !rsp_if.valid) begin
        rsp_if.ready <= 1'b1;
      end else if (random_stall && rsp_if.ready) begin
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
          rsp_if.ready <= 1'b0;
          repeat (gap) @(negedge clk_i);
          rsp_if.ready <= 1'b1;
        end
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.cmd = ffha_pkg::CmdAlloc;
    req_if.request_bytes = '0;
    req_if.free_addr = '0;
  end

  task automatic send_request(input logic cmd, input logic [31:0] req_bytes,
                              input logic [31:0] addr);
    int unsigned gap;
    gap = random_stall ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cmd <= cmd;
    req_if.request_bytes <= req_bytes;
    req_if.free_addr <= addr;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_results.push_back(predict_outcome(cmd, req_bytes, addr));
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_config(input logic [ffha_pkg::CfgIdxW-1:0] idx,
                              input logic [31:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ffha_pkg::CfgHeapBase) heap_base_q = value;
    else heap_bytes_q = value[20:0];
    rebuild_heap();
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_free_addr();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (live_addrs.size() != 0 && r < 8)
      return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
    if (live_addrs.size() != 0 && r == 8)
      return live_addrs[$urandom_range(0, live_addrs.size() - 1)] + 4;
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_size(input logic [20:0] span);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom();
    if (r == 1) return 0;
    if (r < 14) return $urandom_range(1, 64);
    return $urandom_range(1, (span > 64) ? span / 4 : 64);
  endfunction

  task automatic test_directed();
    send_request(ffha_pkg::CmdAlloc, 32'd0, 32'd0);
    send_request(ffha_pkg::CmdAlloc, 32'hFFFF_FFFF, 32'd0);
    send_request(ffha_pkg::CmdAlloc, 32'hFFFF_FFFD, 32'd0);
    send_request(ffha_pkg::CmdAlloc, 32'd1, 32'd0);
    send_request(ffha_pkg::CmdAlloc, 32'd5, 32'd0);
    send_request(ffha_pkg::CmdAlloc, 32'd8, 32'd0);
    send_request(ffha_pkg::CmdFree, 32'hFFFF_FFFF, 32'd28);
    send_request(ffha_pkg::CmdFree, 32'd0, 32'd28);
    send_request(ffha_pkg::CmdFree, 32'd0, 32'hFFFF_FFFF);
    send_request(ffha_pkg::CmdFree, 32'd0, 32'd12);
    send_request(ffha_pkg::CmdFree, 32'd0, 32'd44);
    send_request(ffha_pkg::CmdAlloc, 32'd1048564, 32'd0);
    send_request(ffha_pkg::CmdAlloc, 32'd1048565, 32'd0);
    send_request(ffha_pkg::CmdFree, 32'd0, 32'd12);
  endtask

  task automatic test_config_corners();
    write_config(ffha_pkg::CfgHeapBase, 32'hFFFF_FFF0);
    send_request(ffha_pkg::CmdAlloc, 32'd4, 32'd0);
    send_request(ffha_pkg::CmdAlloc, 32'd4, 32'd0);
    send_request(ffha_pkg::CmdFree, 32'd0, 32'hFFFF_FFFC);
    write_config(ffha_pkg::CfgHeapBytes, 32'h1F_FFFF);
    send_request(ffha_pkg::CmdAlloc, 32'd1048564, 32'd0);
    write_config(ffha_pkg::CfgHeapBytes, 32'd11);
    send_request(ffha_pkg::CmdAlloc, 32'd1, 32'd0);
    send_request(ffha_pkg::CmdFree, 32'd0, 32'hFFFF_FFFC);
    write_config(ffha_pkg::CfgHeapBytes, 32'd12);
    send_request(ffha_pkg::CmdAlloc, 32'd1, 32'd0);
    write_config(ffha_pkg::CfgHeapBytes, 32'd0);
    send_request(ffha_pkg::CmdAlloc, 32'd4, 32'd0);
  endtask

  // fill the table to its limit so that grants stop splitting
  task automatic test_table_full();
    write_config(ffha_pkg::CfgHeapBase, 32'h0000_1000);
    write_config(ffha_pkg::CfgHeapBytes, 32'd4096);
    for (int i = 0; i < 70; i++) send_request(ffha_pkg::CmdAlloc, 32'd4, 32'd0);
    for (int i = 0; i < 20; i++) send_request(ffha_pkg::CmdFree, 32'd0, pick_free_addr());
  endtask

  task automatic test_random(input int unsigned count, input logic [31:0] base,
                             input logic [20:0] bytes);
    write_config(ffha_pkg::CfgHeapBase, base);
    write_config(ffha_pkg::CfgHeapBytes, {11'd0, bytes});
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1)) send_request(ffha_pkg::CmdAlloc, pick_size(bytes), $urandom());
      else send_request(ffha_pkg::CmdFree, $urandom(), pick_free_addr());
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_off_cycles = 1500;
    for (int i = 0; i < 20; i++)
      send_request(ffha_pkg::CmdAlloc, $urandom_range(1, 32), 32'd0);
    wait_idle();
    random_stall = 1'b0;
    for (int i = 0; i < 40; i++)
      send_request(ffha_pkg::CmdAlloc, $urandom_range(1, 32), 32'd0);
    random_stall = 1'b1;
  endtask

  initial begin
    heap_base_q = '0;
    heap_bytes_q = ffha_pkg::HeapBytesReset;
    rebuild_heap();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_config_corners();
    test_table_full();
    test_random(250, $urandom(), 21'd2048);
    test_random(250, 32'h0000_0000, 21'd600);
    test_backpressure();
    test_random(150, $urandom(), 21'h10_0000);
    wait_idle();
    $display("Sent %0d requests, checked %0d results across heap sizes and bases,",
             sent_count, checked_count);
    $display("including full-table, oversize, wrap and back-pressure cases.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
